// ===== design/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants, types and the Paeth predictor for the PNG scanline
// unfilter unit.
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int LINE_BYTES = 4096;
	localparam int ADDR_W     = $clog2(LINE_BYTES);
	localparam int COL_W      = ADDR_W + 1;
	localparam int MAX_BPP    = 8;
	localparam int HIST_W     = $clog2(MAX_BPP);
	localparam int BPP_W      = 4;

	typedef enum logic [2:0] {
		FILT_NONE,
		FILT_SUB,
		FILT_UP,
		FILT_AVG,
		FILT_PAETH,
		FILT_BAD
	} filter_t;

	// Control that travels with a request from the accept edge into stage 1.
	typedef struct packed {
		logic              valid;
		logic              line_start;
		filter_t           filter;
		logic              no_upper;
		logic              col_ok;
		logic [HIST_W-1:0] bpp_idx;
	} recon_ctrl_t;

	// Paeth predictor: the neighbor closest to a + b - c, ties go a, then b.
	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic        [9:0] pa;
		logic        [9:0] pb;
		logic        [9:0] pc;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa = da[9] ? 10'(-da) : 10'(da);
		pb = db[9] ? 10'(-db) : 10'(db);
		pc = dc[9] ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage

// ===== design/png_scanline_unfilter_unit.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// Streaming PNG filter reconstruction (None, Sub, Up, Average, Paeth), one
// byte per request, with the previous scanline held in an on-chip line store.
// ----------------------------------------------------------------------------
// The unit accepts one byte per clock cycle and sustains that rate as long as
// the output side does not stall. A request flagged with line_start carries
// the line's filter type and first_row flag and yields no result. Every other
// request yields exactly one result, which reaches the output register via
// stage 1. The accept edge reads the line store at the current column and
// loads stage 1. When stage 1 fires, it computes the byte, writes it back to
// the line store and loads the output register. A line store entry is
// written after it is read, and the next line cannot read that column
// before the write, so no forwarding is needed. The left and upper-left
// neighbors come from eight-deep history registers that are updated in
// stage 1, so a byte always sees the byte just before it. Filter types above
// four pass bytes through unchanged with bad_filter set. Columns at or beyond
// the store depth read the upper row as zero and are not stored. The line
// store has no reset. A line whose first_row flag is clear must not reach
// past the columns that have been written since reset. The user must write
// bytes_per_pixel through the configuration port only while the unit is
// idle; the unit itself does not enforce this. Zero acts as one, and values
// above eight act as eight.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit import psu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [BPP_W-1:0] cfg_data,
	// input request channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             line_start,
	input  logic             first_row,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       pixel_byte,
	output logic             bad_filter
);

	logic [BPP_W-1:0]  bpp_q;
	logic [COL_W-1:0]  col_q;
	filter_t           filter_q;
	logic              no_upper_q;
	logic [HIST_W-1:0] bpp_idx;
	logic              col_ok;
	logic              in_acc;

	recon_ctrl_t       ctrl_s1;
	logic [7:0]        x_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              s1_adv;
	logic              s1_fire;

	logic [7:0]        upper_raw;
	logic [7:0]        recon_byte;
	logic              recon_bad;

	logic              out_valid_q;
	logic [7:0]        pixel_byte_q;
	logic              bad_filter_q;

	assign cfg_ready = 1'b1;

	// Clamp the pixel size to 1..MAX_BPP and turn it into a history tap.
	always_comb begin
		priority if (bpp_q == '0) begin
			bpp_idx = '0;
		end else if (bpp_q > BPP_W'(MAX_BPP)) begin
			bpp_idx = HIST_W'(MAX_BPP - 1);
		end else begin
			bpp_idx = HIST_W'(bpp_q - 1'b1);
		end
	end

	// Stage 1 moves on when empty, when it holds a line start (no result),
	// or when the output register is free or being taken.
	assign s1_adv   = !ctrl_s1.valid || ctrl_s1.line_start || !out_valid_q || !out_stall;
	assign s1_fire  = ctrl_s1.valid && s1_adv;
	assign in_stall = !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign col_ok   = !col_q[COL_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q      <= BPP_W'(3);
			col_q      <= '0;
			filter_q   <= FILT_NONE;
			no_upper_q <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bpp_q <= cfg_data;
			end
			if (in_acc) begin
				if (line_start) begin
					col_q      <= '0;
					filter_q   <= (data_byte > 8'd4) ? FILT_BAD : filter_t'(data_byte[2:0]);
					no_upper_q <= first_row;
				end else if (col_ok) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Stage 1 control is reset; the payload alongside it is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (s1_adv) begin
			ctrl_s1.valid      <= in_acc;
			ctrl_s1.line_start <= line_start;
			ctrl_s1.filter     <= filter_q;
			ctrl_s1.no_upper   <= no_upper_q;
			ctrl_s1.col_ok     <= col_ok;
			ctrl_s1.bpp_idx    <= bpp_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			x_s1    <= data_byte;
			addr_s1 <= col_q[ADDR_W-1:0];
		end
	end

	psu_line_store u_line_store (
		.clk     (clk),
		.rd_en   (in_acc && !line_start && col_ok),
		.rd_addr (col_q[ADDR_W-1:0]),
		.rd_data (upper_raw),
		.wr_en   (s1_fire && !ctrl_s1.line_start && ctrl_s1.col_ok),
		.wr_addr (addr_s1),
		.wr_data (recon_byte)
	);

	psu_recon u_recon (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_s1),
		.fire      (s1_fire),
		.x         (x_s1),
		.upper_raw (upper_raw),
		.result    (recon_byte),
		.bad       (recon_bad)
	);

	// Output register: parts the result side from the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && !ctrl_s1.line_start) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !ctrl_s1.line_start) begin
			pixel_byte_q <= recon_byte;
			bad_filter_q <= recon_bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_byte_q;
	assign bad_filter = bad_filter_q;

	// The input side only waits behind a byte that still needs the output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (ctrl_s1.valid && !ctrl_s1.line_start && out_valid_q))
		else $error("input stalled without a blocked byte in stage 1");

	// The column counter saturates at the line store depth.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(LINE_BYTES))
		else $error("column counter beyond line store depth");

	// An accepted line start restarts the column count.
	a_col_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && line_start) |=> (col_q == '0))
		else $error("column not cleared after line start");

	// A byte from a line with an out-of-range type comes out flagged.
	a_bad_source: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !ctrl_s1.line_start && ctrl_s1.filter == FILT_BAD)
		|=> (out_valid_q && bad_filter_q))
		else $error("bad filter byte not flagged");

endmodule

// ===== design/psu_line_store.sv =====
// ----------------------------------------------------------------------------
// psu_line_store
// Single-port-write, single-port-read byte memory that holds the previous
// reconstructed scanline. Read data is registered and holds when not read.
// ----------------------------------------------------------------------------
module psu_line_store import psu_pkg::*; (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data
);

	logic [7:0] mem [LINE_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/psu_recon.sv =====
// ----------------------------------------------------------------------------
// psu_recon
// Stage-1 reconstruction: left and upper-left history registers and the
// filter arithmetic that rebuilds one byte from its neighbors.
// ----------------------------------------------------------------------------
module psu_recon import psu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  recon_ctrl_t ctrl,
	input  logic        fire,
	input  logic [7:0]  x,
	input  logic [7:0]  upper_raw,
	output logic [7:0]  result,
	output logic        bad
);

	logic [7:0] left_q     [MAX_BPP];
	logic [7:0] up_left_q  [MAX_BPP];
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] avg_sum;

	assign a       = left_q[ctrl.bpp_idx];
	assign c       = up_left_q[ctrl.bpp_idx];
	assign b       = (ctrl.no_upper || !ctrl.col_ok) ? 8'd0 : upper_raw;
	assign avg_sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		bad = 1'b0;
		unique case (ctrl.filter)
			FILT_NONE:  result = x;
			FILT_SUB:   result = x + a;
			FILT_UP:    result = x + b;
			FILT_AVG:   result = x + avg_sum[8:1];
			FILT_PAETH: result = x + paeth_pick(a, b, c);
			default: begin
				result = x;
				bad    = 1'b1;
			end
		endcase
	end

	// A line start clears both histories so the first pixel sees zero neighbors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BPP; i++) begin
				left_q[i]    <= 8'd0;
				up_left_q[i] <= 8'd0;
			end
		end else if (fire) begin
			if (ctrl.line_start) begin
				for (int i = 0; i < MAX_BPP; i++) begin
					left_q[i]    <= 8'd0;
					up_left_q[i] <= 8'd0;
				end
			end else begin
				left_q[0]    <= result;
				up_left_q[0] <= b;
				for (int i = 1; i < MAX_BPP; i++) begin
					left_q[i]    <= left_q[i-1];
					up_left_q[i] <= up_left_q[i-1];
				end
			end
		end
	end

endmodule
